@@ rtl/core/nms_pkg.sv @@
package nms_pkg;

  // Largest frame height the row counters support.
  localparam int MAX_HEIGHT = 4096;

  // Frame geometry is held at a fixed width that covers every legal width and height.
  localparam int DIM_BITS = 13;
  localparam int ROW_BITS = 12;

  // Configuration register widths and port format.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int WIDTH_REG_BITS = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int THR_BITS = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PEAK = 2'd2;

  localparam int WIDTH_RESET = 640;
  localparam int HEIGHT_RESET = 480;
  localparam logic signed [THR_BITS-1:0] PEAK_RESET = 32'sd1500;

  // Queue between the front and back ends, and the result queue.
  localparam int SLOT_QUEUE_DEPTH = 4;
  localparam int SLOT_QCNT_BITS = $clog2(SLOT_QUEUE_DEPTH + 1);
  localparam int OUT_QUEUE_DEPTH = 8;
  localparam int OUT_QCNT_BITS = $clog2(OUT_QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } geom_t;

endpackage

@@ rtl/core/nms_fifo.sv @@
module nms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr_next;
  logic [AW-1:0]    rd_ptr_next;
  logic [CW-1:0]    count_next;

  assign wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
  assign rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
  assign count_next  = count + CW'(push) - CW'(pop);

  assign pop_data = mem[rd_ptr];
  assign empty    = (count == '0);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr_next;
      if (pop) rd_ptr <= rd_ptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

@@ rtl/core/nms_front.sv @@
module nms_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int PIXEL_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  nms_pkg::geom_t                geom,
  input  logic                          push,
  output logic                          full,
  input  logic signed [PIXEL_BITS-1:0]  pixel_value,
  input  logic                          flush,
  output logic                          q_push,
  output logic [3*PIXEL_BITS:0]         q_data,
  input  logic [nms_pkg::SLOT_QCNT_BITS-1:0] q_count
);

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int PEND_BITS = $clog2(MAX_WIDTH + 2);
  localparam int WORD_BITS = 2 * PIXEL_BITS + 1;
  localparam int QC_BITS   = nms_pkg::SLOT_QCNT_BITS;
  localparam int DB        = nms_pkg::DIM_BITS;
  localparam int RB        = nms_pkg::ROW_BITS;

  // Each line store word holds the upper row, the middle row and the middle row's pixel tag.
  logic [WORD_BITS-1:0] mem [MAX_WIDTH];

  logic [COL_BITS-1:0]  slot_column;
  logic [COL_BITS-1:0]  in_column;
  logic [RB-1:0]        in_row;
  logic [PEND_BITS-1:0] pending;
  logic [PEND_BITS-1:0] pending_next;
  logic                 cv1;
  logic                 filled;

  logic                         b_valid;
  logic [COL_BITS-1:0]          b_col;
  logic signed [PIXEL_BITS-1:0] b_val;
  logic                         b_real;
  logic                         b_filled;
  logic                         b_report;

  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] fwd_word;
  logic                 fwd_sel;
  logic [WORD_BITS-1:0] rd_sel;
  logic [WORD_BITS-1:0] wr_word;
  logic [PIXEL_BITS-1:0] rd_upper;
  logic [PIXEL_BITS-1:0] rd_mid;
  logic                 b_mid_tag;

  logic             accept;
  logic             adv;
  logic             frame_start;
  logic             report_now;
  logic             col_last;
  logic             in_col_last;
  logic             in_row_last;
  logic [QC_BITS:0] used;

  assign used   = {1'b0, q_count} + (QC_BITS + 1)'(b_valid);
  assign full   = (used >= (QC_BITS + 1)'(nms_pkg::SLOT_QUEUE_DEPTH));
  assign accept = push && !full;

  assign frame_start = (in_column == '0) && (in_row == '0);
  // A flush only moves the stream once a frame is complete and pixels still wait.
  assign adv = accept && (!flush || ((pending != '0) && frame_start));

  // A slot reads the line store at the edge where the previous slot writes it back,
  // so when both use the same column, take the word written instead of the read word.
  assign rd_sel    = fwd_sel ? fwd_word : rd_word;
  assign rd_upper  = rd_sel[WORD_BITS-1 -: PIXEL_BITS];
  assign rd_mid    = rd_sel[1 +: PIXEL_BITS];
  assign b_mid_tag = b_filled && rd_sel[0];
  assign wr_word   = {rd_mid, b_val, b_real};

  assign report_now = b_valid ? b_mid_tag : cv1;

  assign col_last    = (DB'(slot_column) + DB'(1)) >= geom.width;
  assign in_col_last = (DB'(in_column) + DB'(1)) >= geom.width;
  assign in_row_last = (DB'(in_row) + DB'(1)) >= geom.height;

  assign pending_next = pending + PEND_BITS'(accept && !flush)
                        - PEND_BITS'(adv && report_now);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      slot_column <= '0;
      in_column   <= '0;
      in_row      <= '0;
      pending     <= '0;
      cv1         <= 1'b0;
      filled      <= 1'b0;
      b_valid     <= 1'b0;
      fwd_sel     <= 1'b0;
    end else begin
      pending <= pending_next;
      b_valid <= adv;
      if (b_valid) cv1 <= b_mid_tag;
      if (adv) begin
        slot_column <= col_last ? '0 : slot_column + COL_BITS'(1);
        if (col_last) filled <= 1'b1;
        fwd_sel <= b_valid && (b_col == slot_column);
      end
      if (accept && !flush) begin
        if (in_col_last) begin
          in_column <= '0;
          in_row    <= in_row_last ? '0 : in_row + RB'(1);
        end else begin
          in_column <= in_column + COL_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_col    <= slot_column;
      b_val    <= flush ? '0 : pixel_value;
      b_real   <= !flush;
      b_filled <= filled;
      b_report <= report_now;
      fwd_word <= wr_word;
    end
  end

  // Line store: read when a slot enters, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (b_valid) mem[b_col] <= wr_word;
    if (adv) rd_word <= mem[slot_column];
  end

  assign q_push = b_valid;
  assign q_data = {b_report, rd_upper, rd_mid, b_val};

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_BITS'(MAX_WIDTH + 1))
    else $error("pending count exceeds the delay line length");

  a_slot_col_range: assert property (@(posedge clk) disable iff (rst)
    DB'(slot_column) < geom.width)
    else $error("slot column outside the frame width");

  a_midframe_flush: assert property (@(posedge clk) disable iff (rst || clear)
    (accept && flush && !frame_start) |=> !b_valid)
    else $error("mid-frame flush advanced the stream");

endmodule

@@ rtl/core/nms_back.sv @@
module nms_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int PIXEL_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clear,
  input  nms_pkg::geom_t                         geom,
  input  logic signed [nms_pkg::THR_BITS-1:0]    thr,
  input  logic                                   q_empty,
  input  logic [3*PIXEL_BITS:0]                  q_data,
  output logic                                   q_pop,
  input  logic [nms_pkg::OUT_QCNT_BITS-1:0]      o_count,
  output logic                                   o_push,
  output logic [PIXEL_BITS+1:0]                  o_data
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int DB       = nms_pkg::DIM_BITS;
  localparam int RB       = nms_pkg::ROW_BITS;
  localparam int CB       = nms_pkg::OUT_QCNT_BITS + 1;
  localparam int XB       = (PIXEL_BITS > nms_pkg::THR_BITS) ? PIXEL_BITS : nms_pkg::THR_BITS;

  function automatic logic signed [PIXEL_BITS-1:0] smax(
    input logic signed [PIXEL_BITS-1:0] a,
    input logic signed [PIXEL_BITS-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  logic                         h_report;
  logic signed [PIXEL_BITS-1:0] h_top;
  logic signed [PIXEL_BITS-1:0] h_mid;
  logic signed [PIXEL_BITS-1:0] h_val;

  logic signed [PIXEL_BITS-1:0] win [9];
  logic [COL_BITS-1:0]          out_column;
  logic [RB-1:0]                out_row;

  logic       s0_v, s1_v, s2_v, s3_v;
  logic [8:0] s0_ok;
  logic       s0_last, s1_last, s2_last, s3_last;

  logic signed [PIXEL_BITS-1:0] mv [9];
  logic signed [PIXEL_BITS-1:0] s1_m [4];
  logic signed [PIXEL_BITS-1:0] s1_centre, s2_centre, s3_centre;
  logic                         s1_ge, s2_ge, s3_ge;
  logic signed [PIXEL_BITS-1:0] s2_n0, s2_n1, s2_cz;
  logic signed [PIXEL_BITS-1:0] s3_p, s3_cz;
  logic signed [PIXEL_BITS-1:0] peak;
  logic                         kept;

  logic signed [XB-1:0] centre_x;
  logic signed [XB-1:0] thr_x;

  logic [2:0]    inflight;
  logic [CB-1:0] used;
  logic          credit;
  logic          pop_report;
  logic          up_ok, dn_ok, lf_ok, rt_ok;
  logic          col_last, row_last;

  assign h_report = q_data[3*PIXEL_BITS];
  assign h_top    = q_data[3*PIXEL_BITS-1 -: PIXEL_BITS];
  assign h_mid    = q_data[2*PIXEL_BITS-1 -: PIXEL_BITS];
  assign h_val    = q_data[PIXEL_BITS-1:0];

  // Every result in the pipeline already holds a place in the result queue.
  assign inflight = 3'(s0_v) + 3'(s1_v) + 3'(s2_v) + 3'(s3_v);
  assign used     = CB'(o_count) + CB'(inflight);
  assign credit   = used < CB'(nms_pkg::OUT_QUEUE_DEPTH);
  assign q_pop    = !q_empty && (!h_report || credit);
  assign pop_report = q_pop && h_report;

  assign col_last = (DB'(out_column) + DB'(1)) >= geom.width;
  assign row_last = (DB'(out_row) + DB'(1)) >= geom.height;
  assign up_ok    = (out_row != '0);
  assign dn_ok    = !row_last;
  assign lf_ok    = (out_column != '0);
  assign rt_ok    = !col_last;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      out_column <= '0;
      out_row    <= '0;
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s0_v <= pop_report;
      s1_v <= s0_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (pop_report) begin
        if (col_last) begin
          out_column <= '0;
          out_row    <= row_last ? '0 : out_row + RB'(1);
        end else begin
          out_column <= out_column + COL_BITS'(1);
        end
      end
    end
  end

  // Window shift and neighbor masks for the pixel now at the centre.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= h_top;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= h_mid;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= h_val;
      s0_ok  <= {dn_ok && rt_ok, dn_ok, dn_ok && lf_ok, rt_ok, 1'b1, lf_ok,
                 up_ok && rt_ok, up_ok, up_ok && lf_ok};
      s0_last <= row_last && col_last;
    end
  end

  // Out-of-frame neighbors count as zero, which matches a maximum that starts at zero.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mv[i] = s0_ok[i] ? win[i] : '0;
    end
  end

  assign centre_x = XB'(win[4]);
  assign thr_x    = XB'(thr);

  always_ff @(posedge clk) begin
    s1_m[0]   <= smax(mv[0], mv[1]);
    s1_m[1]   <= smax(mv[2], mv[3]);
    s1_m[2]   <= smax(mv[5], mv[6]);
    s1_m[3]   <= smax(mv[7], mv[8]);
    s1_centre <= win[4];
    s1_ge     <= centre_x >= thr_x;
    s1_last   <= s0_last;

    s2_n0     <= smax(s1_m[0], s1_m[1]);
    s2_n1     <= smax(s1_m[2], s1_m[3]);
    s2_cz     <= s1_centre[PIXEL_BITS-1] ? '0 : s1_centre;
    s2_centre <= s1_centre;
    s2_ge     <= s1_ge;
    s2_last   <= s1_last;

    s3_p      <= smax(s2_n0, s2_n1);
    s3_cz     <= s2_cz;
    s3_centre <= s2_centre;
    s3_ge     <= s2_ge;
    s3_last   <= s2_last;
  end

  assign peak   = smax(s3_p, s3_cz);
  assign kept   = (s3_centre == peak) && s3_ge;
  assign o_push = s3_v;
  assign o_data = {kept ? s3_centre : '0, kept, s3_last};

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    o_push |-> (o_count < nms_pkg::OUT_QCNT_BITS'(nms_pkg::OUT_QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_out_col_range: assert property (@(posedge clk) disable iff (rst)
    DB'(out_column) < geom.width)
    else $error("output column outside the frame width");

endmodule

@@ rtl/core/nonmax_suppression_3x3.sv @@
// 3x3 non-maximum suppression over a raster-order stream of corner responses.
// Input queue side: drive pixel_value and flush and raise push; the word is
// taken at a clock edge where push is high and full is low. A flush word with
// no pixel drains the last row and column once a frame is complete; flushes in
// mid-frame or with nothing pending are dropped without a result.
// Result queue side: while empty is low the oldest result is on kept_value,
// is_peak and end_of_frame; pop at an edge with empty low takes it.
// A pixel's result is formed when it reaches the window centre, W+1 stream
// slots after it entered (W = frame width). One word is accepted per clock
// while full is low; the line store (one read and one write port) is touched
// once per slot.
// If the receiver stalls, results collect in an eight-word result queue and a
// four-word slot queue; full rises only when both are taken up.
// Reset restores width 640, height 480, threshold 1500 and empties the stream.
// Width, height or threshold writes restart the stream; write only while idle.
module nonmax_suppression_3x3 #(
  parameter int MAX_WIDTH = 1024,
  parameter int PIXEL_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [PIXEL_BITS-1:0]           pixel_value,
  input  logic                                   flush,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [PIXEL_BITS-1:0]           kept_value,
  output logic                                   is_peak,
  output logic                                   end_of_frame,
  input  logic                                   cfg_write,
  input  logic [nms_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [nms_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int DB = nms_pkg::DIM_BITS;
  localparam int SW = 3 * PIXEL_BITS + 1;
  localparam int OW = PIXEL_BITS + 2;
  localparam logic [DB-1:0] WIDTH_AT_RESET = (nms_pkg::WIDTH_RESET > MAX_WIDTH) ?
      DB'(MAX_WIDTH) : DB'(nms_pkg::WIDTH_RESET);

  nms_pkg::geom_t                        geom;
  logic signed [nms_pkg::THR_BITS-1:0]   thr;
  logic                                  clear;
  logic [nms_pkg::WIDTH_REG_BITS-1:0]    wv;
  logic [nms_pkg::HEIGHT_REG_BITS-1:0]   hv;
  logic [DB-1:0]                         w_new;
  logic [DB-1:0]                         h_new;

  logic                                  s_push;
  logic [SW-1:0]                         s_wdata;
  logic                                  s_pop;
  logic [SW-1:0]                         s_rdata;
  logic                                  s_empty;
  logic [nms_pkg::SLOT_QCNT_BITS-1:0]    s_count;

  logic                                  o_push;
  logic [OW-1:0]                         o_wdata;
  logic [OW-1:0]                         o_rdata;
  logic [nms_pkg::OUT_QCNT_BITS-1:0]     o_count;

  assign clear = cfg_write && ((cfg_index == nms_pkg::REG_FRAME_WIDTH) ||
                               (cfg_index == nms_pkg::REG_FRAME_HEIGHT) ||
                               (cfg_index == nms_pkg::REG_MIN_PEAK));

  // Low register bits are kept, and zero or over-large geometry is clamped.
  assign wv = cfg_data[nms_pkg::WIDTH_REG_BITS-1:0];
  assign hv = cfg_data[nms_pkg::HEIGHT_REG_BITS-1:0];
  assign w_new = (wv == '0) ? DB'(1) :
                 (DB'(wv) > DB'(MAX_WIDTH)) ? DB'(MAX_WIDTH) : DB'(wv);
  assign h_new = (hv == '0) ? DB'(1) :
                 (DB'(hv) > DB'(nms_pkg::MAX_HEIGHT)) ? DB'(nms_pkg::MAX_HEIGHT) : DB'(hv);

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.width  <= WIDTH_AT_RESET;
      geom.height <= DB'(nms_pkg::HEIGHT_RESET);
      thr         <= nms_pkg::PEAK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nms_pkg::REG_FRAME_WIDTH:  geom.width  <= w_new;
        nms_pkg::REG_FRAME_HEIGHT: geom.height <= h_new;
        nms_pkg::REG_MIN_PEAK:     thr <= cfg_data[nms_pkg::THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  nms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .clear       (clear),
    .geom        (geom),
    .push        (push),
    .full        (full),
    .pixel_value (pixel_value),
    .flush       (flush),
    .q_push      (s_push),
    .q_data      (s_wdata),
    .q_count     (s_count)
  );

  nms_fifo #(
    .WIDTH (SW),
    .DEPTH (nms_pkg::SLOT_QUEUE_DEPTH)
  ) u_slot_queue (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .push      (s_push),
    .push_data (s_wdata),
    .pop       (s_pop),
    .pop_data  (s_rdata),
    .empty     (s_empty),
    .count     (s_count)
  );

  nms_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .geom    (geom),
    .thr     (thr),
    .q_empty (s_empty),
    .q_data  (s_rdata),
    .q_pop   (s_pop),
    .o_count (o_count),
    .o_push  (o_push),
    .o_data  (o_wdata)
  );

  nms_fifo #(
    .WIDTH (OW),
    .DEPTH (nms_pkg::OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .push      (o_push),
    .push_data (o_wdata),
    .pop       (pop && !empty),
    .pop_data  (o_rdata),
    .empty     (empty),
    .count     (o_count)
  );

  assign kept_value   = o_rdata[OW-1:2];
  assign is_peak      = o_rdata[1];
  assign end_of_frame = o_rdata[0];

endmodule
